/* sv/cmf_pkg.sv */
// Shared types and constants for the inter-core mailbox FIFO array.
// Used by cmf_ctrl and core_mailbox_fifo_array_core; no dependencies.
package cmf_pkg;

    localparam logic [1:0] MODE_WRITE = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_STALL = 2'd2;

    // Window 0xFFEC0000..0xFFEC3FFF: upper 18 bits fixed, bits 13:12 pick the mailbox
    localparam logic [31:0] WIN_BASE   = 32'hFFEC0000;
    localparam int          WIN_LSB    = 14;
    localparam int          MBOX_SHIFT = 12;
    localparam int          QUERY_BIT  = 2;
    localparam int          NUM_CORES  = 4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  core_index;
        logic        core_valid;
        logic [31:0] bus_address;
        logic [31:0] write_data;
    } cmf_in_t;

    typedef struct packed {
        logic        handled;
        logic [31:0] read_data;
        logic        stall_set;
        logic        write_dropped;
        logic        stall_was_pending;
    } cmf_out_t;

    // Result of the execute stage; pop_data selects the RAM read word
    typedef struct packed {
        logic        handled;
        logic [31:0] read_data;
        logic        stall_set;
        logic        write_dropped;
        logic        stall_was_pending;
        logic        pop_data;
    } cmf_res_t;

endpackage

/* sv/cmf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
module cmf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* sv/cmf_ctrl.sv */
// Access decode, per-FIFO head/fill pointers and per-core stall flags.
// Depends on cmf_pkg; drives the word RAM ports of cmf_ram.
module cmf_ctrl #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           fire,
    input  cmf_pkg::cmf_in_t                               item,
    output cmf_pkg::cmf_res_t                              res,
    output logic                                           ram_we,
    output logic [$clog2(cmf_pkg::NUM_CORES*cmf_pkg::NUM_CORES*FIFO_DEPTH)-1:0] ram_waddr,
    output logic [31:0]                                    ram_wdata,
    output logic                                           ram_re,
    output logic [$clog2(cmf_pkg::NUM_CORES*cmf_pkg::NUM_CORES*FIFO_DEPTH)-1:0] ram_raddr
);
    import cmf_pkg::*;

    localparam int NUM_FIFOS = NUM_CORES * NUM_CORES;
    localparam int AW        = $clog2(NUM_FIFOS * FIFO_DEPTH);
    localparam int PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FILL_W    = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W     = FILL_W + 1;
    localparam int FIFO_W    = $clog2(NUM_FIFOS);

    logic [PTR_W-1:0]  head_reg  [NUM_FIFOS];
    logic [FILL_W-1:0] fill_reg  [NUM_FIFOS];
    logic [NUM_CORES-1:0] stall_flags_reg;

    logic [1:0]        mbox;
    logic              in_win;
    logic              query;
    logic [FIFO_W-1:0] fifo_sel;
    logic [PTR_W-1:0]  head_cur;
    logic [FILL_W-1:0] fill_cur;
    logic              full;
    logic              empty;
    logic [SUM_W-1:0]  tail_sum;
    logic [PTR_W-1:0]  tail;
    logic [PTR_W-1:0]  head_inc;
    logic [AW-1:0]     fifo_base;
    logic              do_push;
    logic              do_pop;
    logic              do_stall_set;
    logic              do_stall_clr;

    assign in_win = item.bus_address[31:WIN_LSB] == WIN_BASE[31:WIN_LSB];
    assign mbox   = item.bus_address[MBOX_SHIFT+1:MBOX_SHIFT];
    assign query  = item.bus_address[QUERY_BIT];

    // Writes go to FIFO[sender][mbox], reads come from FIFO[mbox][reader]
    assign fifo_sel = (item.mode == MODE_READ) ? {mbox, item.core_index}
                                               : {item.core_index, mbox};

    assign head_cur = head_reg[fifo_sel];
    assign fill_cur = fill_reg[fifo_sel];
    assign full     = fill_cur == FILL_W'(FIFO_DEPTH);
    assign empty    = fill_cur == '0;

    // Tail slot: head + fill, wrapped once
    assign tail_sum = SUM_W'(head_cur) + SUM_W'(fill_cur);
    assign tail     = (tail_sum >= SUM_W'(FIFO_DEPTH)) ?
                      PTR_W'(tail_sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc = (head_cur == PTR_W'(FIFO_DEPTH - 1)) ? '0 : PTR_W'(head_cur + 1'b1);

    assign fifo_base = AW'(fifo_sel) * AW'(FIFO_DEPTH);

    always_comb begin
        res          = '0;
        do_push      = 1'b0;
        do_pop       = 1'b0;
        do_stall_set = 1'b0;
        do_stall_clr = 1'b0;
        unique case (item.mode)
            MODE_WRITE: begin
                if (in_win) begin
                    res.handled = 1'b1;
                    if (item.core_valid) begin
                        if (full) begin
                            res.write_dropped = 1'b1;
                        end else begin
                            do_push = 1'b1;
                        end
                    end
                end
            end
            MODE_READ: begin
                if (in_win) begin
                    res.handled = 1'b1;
                    if (item.core_valid) begin
                        if (query) begin
                            res.read_data = {31'b0, !empty};
                        end else if (empty) begin
                            res.stall_set = 1'b1;
                            do_stall_set  = 1'b1;
                        end else begin
                            res.pop_data = 1'b1;
                            do_pop       = 1'b1;
                        end
                    end
                end
            end
            MODE_STALL: begin
                if (item.core_valid) begin
                    res.handled           = 1'b1;
                    res.stall_was_pending = stall_flags_reg[item.core_index];
                    do_stall_clr          = 1'b1;
                end
            end
            default: begin
                res = '0;
            end
        endcase
    end

    assign ram_we    = fire && do_push;
    assign ram_waddr = fifo_base + AW'(tail);
    assign ram_wdata = item.write_data;
    assign ram_re    = fire && do_pop;
    assign ram_raddr = fifo_base + AW'(head_cur);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_FIFOS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
            stall_flags_reg <= '0;
        end else if (fire) begin
            if (do_push) begin
                fill_reg[fifo_sel] <= FILL_W'(fill_cur + 1'b1);
            end
            if (do_pop) begin
                head_reg[fifo_sel] <= head_inc;
                fill_reg[fifo_sel] <= FILL_W'(fill_cur - 1'b1);
            end
            if (do_stall_set) begin
                stall_flags_reg[item.core_index] <= 1'b1;
            end
            if (do_stall_clr) begin
                stall_flags_reg[item.core_index] <= 1'b0;
            end
        end
    end

    a_no_push_and_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("push and pop issued in the same cycle");

    a_fill_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |-> fill_cur <= FILL_W'(FIFO_DEPTH))
        else $error("fill count above FIFO depth");

    a_push_grows_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |=> fill_reg[$past(fifo_sel)] == FILL_W'($past(fill_cur) + 1'b1))
        else $error("push did not advance fill count");

    a_stall_flag_set: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res.stall_set |=> stall_flags_reg[$past(item.core_index)])
        else $error("empty pop did not set the stall flag");

endmodule

/* sv/core_mailbox_fifo_array_core.sv */
// Inter-core mailbox: 4x4 array of word FIFOs behind a valid/ready transaction port.
// Each accepted transaction is held in the input register, then executed into the result register.
// Throughput: one transaction per cycle; s_ready drops only while a result waits on m_ready.
// Pop data comes from the word RAM's registered read port in the result cycle.
// Reset clears head pointers, fill counts and stall flags at once; word storage is not cleared.
// Depends on cmf_pkg, cmf_ctrl and cmf_ram.
module core_mailbox_fifo_array_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cmf_pkg::cmf_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cmf_pkg::cmf_out_t m_data
);
    import cmf_pkg::*;

    localparam int NUM_WORDS = NUM_CORES * NUM_CORES * FIFO_DEPTH;
    localparam int AW        = $clog2(NUM_WORDS);

    cmf_in_t     in_reg;
    logic        in_valid_reg;
    cmf_res_t    res_reg;
    logic        res_valid_reg;
    cmf_res_t    res_next;
    logic        advance;
    logic        fire;
    logic        ram_we;
    logic        ram_re;
    logic [AW-1:0] ram_waddr;
    logic [AW-1:0] ram_raddr;
    logic [31:0] ram_wdata;
    logic [31:0] ram_rdata;

    assign advance = !res_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                res_valid_reg <= in_valid_reg;
            end
        end
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

    cmf_ctrl #(
        .FIFO_DEPTH(FIFO_DEPTH)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .item      (in_reg),
        .res       (res_next),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr)
    );

    cmf_ram #(
        .WIDTH(32),
        .DEPTH(NUM_WORDS)
    ) u_words (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // RAM read port only moves on fire, so popped data holds while the result stalls
    assign m_valid                = res_valid_reg;
    assign m_data.handled           = res_reg.handled;
    assign m_data.read_data         = res_reg.pop_data ? ram_rdata : res_reg.read_data;
    assign m_data.stall_set         = res_reg.stall_set;
    assign m_data.write_dropped     = res_reg.write_dropped;
    assign m_data.stall_was_pending = res_reg.stall_was_pending;

    a_pop_needs_handled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && res_reg.pop_data |-> res_reg.handled && !res_reg.stall_set)
        else $error("pop result without handled access");

    a_fire_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> m_valid)
        else $error("executed transaction produced no result");

    a_stall_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(res_reg.stall_set && res_reg.write_dropped))
        else $error("stall and drop flagged on one result");

endmodule
